### hdl/dmcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmcs_pkg: shared types and constants of the dot-matrix character serializer
// Field widths, operation codes and the word that travels from the front part
// to the back part through the decoupling queue.
// ----------------------------------------------------------------------------
package dmcs_pkg;

   // Input field widths.
   localparam int OP_W     = 2;
   localparam int CODE_W   = 7;
   localparam int COLUMN_W = 3;
   localparam int VALUE_W  = 8;
   localparam int DOTS_W   = 7;

   // Serial bits sent for one glyph column or one control word.
   localparam int COLUMN_BITS = 8;
   localparam int BIT_W       = 3;
   localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(COLUMN_BITS - 1);

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Operation codes of the op field; the fourth code is unused.
   localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
   localparam logic [OP_W-1:0] OP_CTRL = 2'd1;
   localparam logic [OP_W-1:0] OP_FONT = 2'd2;

   // Kind of work the back part carries out.
   typedef enum logic [1:0] {
      KIND_CHAR,
      KIND_CTRL,
      KIND_FONT
   } entry_kind_type;

   // One classified word in the queue.
   typedef struct packed {
      entry_kind_type         kind;
      logic [CODE_W-1:0]      code;
      logic [COLUMN_W-1:0]    column;
      logic [VALUE_W-1:0]     value;
      logic                   frame_start;
      logic                   frame_end;
   } queue_entry_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

### hdl/dmcs_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmcs_req_if: input channel of the serializer
// Carries one operation word with valid and ready.
// ----------------------------------------------------------------------------
interface dmcs_req_if;
   logic                          valid;
   logic                          ready;
   logic [dmcs_pkg::OP_W-1:0]     op;
   logic [dmcs_pkg::CODE_W-1:0]   code;
   logic [dmcs_pkg::COLUMN_W-1:0] column;
   logic [dmcs_pkg::VALUE_W-1:0]  value;

   modport source (output valid, op, code, column, value, input ready);
   modport sink   (input valid, op, code, column, value, output ready);
endinterface
`default_nettype wire

### hdl/dmcs_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmcs_rsp_if: result channel of the serializer
// Carries one serial bit with its framing marks, with valid and ready.
// ----------------------------------------------------------------------------
interface dmcs_rsp_if;
   logic valid;
   logic ready;
   logic data_bit;
   logic reg_select;
   logic frame_start;
   logic frame_end;
   logic last;

   modport source (output valid, data_bit, reg_select, frame_start, frame_end, last,
                   input ready);
   modport sink   (input valid, data_bit, reg_select, frame_start, frame_end, last,
                   output ready);
endinterface
`default_nettype wire

### hdl/dmcs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmcs_front: accepts and classifies input words
// Decodes the operation, tracks the character position in the open frame and
// pushes one classified word per useful operation into the queue.
// ----------------------------------------------------------------------------
module dmcs_front #(
   parameter int CHARS_PER_FRAME = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   dmcs_req_if.sink                        req_ch,
   input  wire dmcs_pkg::queue_status_type q_status,
   output logic                            push,
   output dmcs_pkg::queue_entry_type       push_entry
);

   localparam int POS_W = (CHARS_PER_FRAME > 1) ? $clog2(CHARS_PER_FRAME) : 1;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(CHARS_PER_FRAME - 1);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             accept;

   // A word is taken whenever the queue has room.
   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && !q_status.full;

   // Classify the word and work out the frame marks of a character.
   always_comb begin
      push                   = 1'b0;
      pos_in                 = pos_ff;
      push_entry.kind        = dmcs_pkg::KIND_FONT;
      push_entry.code        = req_ch.code;
      push_entry.column      = req_ch.column;
      push_entry.value       = req_ch.value;
      push_entry.frame_start = 1'b1;
      push_entry.frame_end   = 1'b1;
      case (req_ch.op)
         dmcs_pkg::OP_CHAR: begin
            push                   = accept;
            push_entry.kind        = dmcs_pkg::KIND_CHAR;
            push_entry.frame_start = (pos_ff == '0);
            push_entry.frame_end   = (pos_ff == LAST_POS);
            if (accept) begin
               pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + POS_W'(1);
            end
         end
         dmcs_pkg::OP_CTRL: begin
            // A control word is a frame of its own and aborts a partial one.
            push            = accept;
            push_entry.kind = dmcs_pkg::KIND_CTRL;
            if (accept) begin
               pos_in = '0;
            end
         end
         dmcs_pkg::OP_FONT: begin
            push            = accept;
            push_entry.kind = dmcs_pkg::KIND_FONT;
         end
         default: begin
            // The unused code is taken and dropped.
            push = 1'b0;
         end
      endcase
   end

   // Character position register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule
`default_nettype wire

### hdl/dmcs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmcs_queue: short queue between the front and back parts
// Holds classified words in arrival order so that each side stalls on its own.
// ----------------------------------------------------------------------------
module dmcs_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire dmcs_pkg::queue_entry_type   push_entry,
   input  wire logic                        pop,
   output dmcs_pkg::queue_entry_type        pop_entry,
   output dmcs_pkg::queue_status_type       status
);

   localparam int PTR_W = (dmcs_pkg::QUEUE_DEPTH > 1) ? $clog2(dmcs_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(dmcs_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(dmcs_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(dmcs_pkg::QUEUE_DEPTH);

   dmcs_pkg::queue_entry_type slot_ff [dmcs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign pop_entry    = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

### hdl/dmcs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmcs_back: carries out queued words
// Owns the glyph memory, writes font columns, and shifts characters and
// control words out one bit per result word through an output register.
// ----------------------------------------------------------------------------
module dmcs_back #(
   parameter int GLYPH_COUNT   = 128,
   parameter int GLYPH_COLUMNS = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dmcs_pkg::queue_entry_type  q_entry,
   input  wire dmcs_pkg::queue_status_type q_status,
   output logic                            pop,
   dmcs_rsp_if.source                      rsp_ch
);

   localparam int DEPTH  = GLYPH_COUNT * GLYPH_COLUMNS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COL_W  = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_COLUMNS - 1);
   localparam logic [8:0] CODE_LIMIT = 9'(GLYPH_COUNT);
   localparam logic [3:0] COL_LIMIT  = 4'(GLYPH_COLUMNS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SHIFT
   } state_type;

   // Glyph memory and its registered read port.
   logic [dmcs_pkg::DOTS_W-1:0] glyph_mem [DEPTH];
   logic [dmcs_pkg::DOTS_W-1:0] rd_data_ff;
   logic                        rd_en;
   logic [ADDR_W-1:0]           rd_addr;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;

   state_type                    state_ff, state_in;
   logic [dmcs_pkg::CODE_W-1:0]  code_ff, code_in;
   logic                         code_ok_ff, code_ok_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [dmcs_pkg::BIT_W-1:0]   bit_ff, bit_in;
   logic [dmcs_pkg::COLUMN_BITS-1:0] sh_ff, sh_in;
   logic                         ctrl_ff, ctrl_in;
   logic                         first_ff, first_in;
   logic                         fend_ff, fend_in;
   logic                         valid_ff, valid_in;
   logic                         data_ff, data_in;
   logic                         rs_ff, rs_in;
   logic                         fs_ff, fs_in;
   logic                         fe_ff, fe_in;
   logic                         last_ff, last_in;

   logic                         out_free;
   logic                         emit;
   logic                         fin;
   logic                         item_done;
   logic                         can_take;
   logic [dmcs_pkg::DOTS_W-1:0]  dots;

   // Memory address of one glyph column.
   function automatic logic [ADDR_W-1:0] glyph_addr(input logic [dmcs_pkg::CODE_W-1:0] c,
                                                     input int k);
      return ADDR_W'(int'(c) * GLYPH_COLUMNS + k);
   endfunction

   // Bit order reversal, so control words leave most significant bit first.
   function automatic logic [dmcs_pkg::VALUE_W-1:0] reverse_bits(
      input logic [dmcs_pkg::VALUE_W-1:0] v);
      logic [dmcs_pkg::VALUE_W-1:0] r;
      for (int i = 0; i < dmcs_pkg::VALUE_W; i++) begin
         r[i] = v[dmcs_pkg::VALUE_W-1-i];
      end
      return r;
   endfunction

   assign out_free  = !valid_ff || rsp_ch.ready;
   assign emit      = (state_ff == ST_SHIFT) && out_free;
   assign fin       = (bit_ff == dmcs_pkg::BIT_LAST) && (ctrl_ff || col_ff == '0);
   assign item_done = emit && fin;
   assign can_take  = (state_ff == ST_IDLE) || item_done;
   assign dots      = code_ok_ff ? rd_data_ff : '0;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      code_ok_in = code_ok_ff;
      col_in     = col_ff;
      bit_in     = bit_ff;
      sh_in      = sh_ff;
      ctrl_in    = ctrl_ff;
      first_in   = first_ff;
      fend_in    = fend_ff;
      valid_in   = valid_ff;
      data_in    = data_ff;
      rs_in      = rs_ff;
      fs_in      = fs_ff;
      fe_in      = fe_ff;
      last_in    = last_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = glyph_addr(q_entry.code, int'(q_entry.column));
      pop        = 1'b0;

      // Output register: load a new bit or drop the one just taken.
      if (emit) begin
         valid_in = 1'b1;
         data_in  = sh_ff[0];
         rs_in    = ctrl_ff;
         fs_in    = first_ff;
         fe_in    = fin && fend_ff;
         last_in  = fin;
         sh_in    = sh_ff >> 1;
         bit_in   = bit_ff + dmcs_pkg::BIT_W'(1);
         first_in = 1'b0;
         if (bit_ff == dmcs_pkg::BIT_LAST && !fin) begin
            // Next column was prefetched; fetch the one after it.
            col_in = col_ff - COL_W'(1);
            sh_in  = {dots, 1'b0};
            bit_in = '0;
            if (col_ff > COL_W'(1)) begin
               rd_en   = 1'b1;
               rd_addr = glyph_addr(code_ff, int'(col_ff) - 2);
            end
         end
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            // First column arrives from memory; prefetch the next one.
            sh_in    = {dots, 1'b0};
            bit_in   = '0;
            state_in = ST_SHIFT;
            if (col_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = glyph_addr(code_ff, int'(col_ff) - 1);
            end
         end
         ST_SHIFT: begin
            if (item_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Take the next queued word as soon as the current one is finished.
      if (can_take && !q_status.empty) begin
         pop      = 1'b1;
         first_in = q_entry.frame_start;
         fend_in  = q_entry.frame_end;
         case (q_entry.kind)
            dmcs_pkg::KIND_CHAR: begin
               code_in    = q_entry.code;
               code_ok_in = ({2'b00, q_entry.code} < CODE_LIMIT);
               col_in     = LAST_COL;
               ctrl_in    = 1'b0;
               rd_en      = 1'b1;
               rd_addr    = glyph_addr(q_entry.code, GLYPH_COLUMNS - 1);
               state_in   = ST_LOAD;
            end
            dmcs_pkg::KIND_CTRL: begin
               ctrl_in  = 1'b1;
               sh_in    = reverse_bits(q_entry.value);
               bit_in   = '0;
               state_in = ST_SHIFT;
            end
            default: begin
               // Font column write; out-of-range codes and columns are ignored.
               wr_en    = ({2'b00, q_entry.code} < CODE_LIMIT) &&
                          ({1'b0, q_entry.column} < COL_LIMIT);
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      code_ff    <= code_in;
      code_ok_ff <= code_ok_in;
      col_ff     <= col_in;
      bit_ff     <= bit_in;
      sh_ff      <= sh_in;
      ctrl_ff    <= ctrl_in;
      first_ff   <= first_in;
      fend_ff    <= fend_in;
      data_ff    <= data_in;
      rs_ff      <= rs_in;
      fs_ff      <= fs_in;
      fe_ff      <= fe_in;
      last_ff    <= last_in;
   end

   // Glyph memory with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         glyph_mem[wr_addr] <= q_entry.value[dmcs_pkg::DOTS_W-1:0];
      end
      if (rd_en) begin
         rd_data_ff <= glyph_mem[rd_addr];
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.data_bit    = data_ff;
   assign rsp_ch.reg_select  = rs_ff;
   assign rsp_ch.frame_start = fs_ff;
   assign rsp_ch.frame_end   = fe_ff;
   assign rsp_ch.last        = last_ff;

endmodule
`default_nettype wire

### hdl/dot_matrix_char_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dot_matrix_char_serializer: serial driver for a dot-matrix display
// Turns character, control-word and font-write words into serial bits.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one operation word: a character to show, a control word,
//   or one glyph column to load into the font memory. rsp_ch carries one
//   serial bit per word with register-select and framing marks; last marks
//   the final bit caused by an input word.
//   A character gives 8*GLYPH_COLUMNS result words (40 by default); a control
//   word gives 8; a font write gives none.
//   The first bit of a character waits for the glyph memory read of its
//   first column; a control word needs no memory read.
//   Throughput: one result word per cycle while the receiver does not stall;
//   each character also passes a load state for the glyph memory read of
//   its first column. A two-word queue lets input words be taken while a
//   character is still being shifted out.
//   Reset clears the queue, the character position and the output register;
//   the font memory is not cleared and must be loaded before use.
//   When the receiver stalls, the output register holds its bit, shifting
//   pauses, and input words are taken until the queue is full.
// ----------------------------------------------------------------------------
module dot_matrix_char_serializer #(
   parameter int CHARS_PER_FRAME = 8,
   parameter int GLYPH_COUNT     = 128,
   parameter int GLYPH_COLUMNS   = 5
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dmcs_req_if.sink   req_ch,
   dmcs_rsp_if.source rsp_ch
);

   dmcs_pkg::queue_status_type q_status;
   dmcs_pkg::queue_entry_type  push_entry;
   dmcs_pkg::queue_entry_type  pop_entry;
   logic                       push;
   logic                       pop;

   // Front part: accept and classify.
   dmcs_front #(
      .CHARS_PER_FRAME (CHARS_PER_FRAME)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue between the two parts.
   dmcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   // Back part: font memory and bit shifter.
   dmcs_back #(
      .GLYPH_COUNT   (GLYPH_COUNT),
      .GLYPH_COLUMNS (GLYPH_COLUMNS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_entry  (pop_entry),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

`ifndef SYNTHESIS
   // A frame only latches on the final bit of a word.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_end |-> rsp_ch.last)
      else $error("frame_end on a bit that is not the last of its word");

   // The first bit of a frame is never the final bit of its word.
   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_start |-> !rsp_ch.last)
      else $error("frame_start on the last bit of a word");

   // Every control word is its own frame, so its final bit latches.
   a_ctrl_latches: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.reg_select && rsp_ch.last |-> rsp_ch.frame_end)
      else $error("control word ended without latching its frame");
`endif

endmodule
`default_nettype wire

### dv/tb_dot_matrix_char_serializer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dot_matrix_char_serializer: self-checking bench for the display serializer
// A short table of directed words covers control-word extremes, glyph loads
// with dropped and ignored bits, the unused opcode and a frame aborted by a
// control word. Bursts of random glyph loads, character runs, control words
// and noise follow. Every serial bit is compared with a cycle-free predictor,
// under phases of sender idling, receiver stalls and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_dot_matrix_char_serializer;

   localparam int CHARS_PER_FRAME = 8;
   localparam int GLYPH_COUNT     = 128;
   localparam int GLYPH_COLUMNS   = 5;

   localparam logic [dmcs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int ITEM_TARGET    = 310;
   localparam int DIRECTED_ROWS  = 25;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int REPORT_LIMIT   = 10;

   // One serial bit with its marks, in the order of the result channel.
   typedef struct packed {
      logic data_bit;
      logic reg_select;
      logic frame_start;
      logic frame_end;
      logic last;
   } serial_bit_type;

   // How the results of a directed word are expected.
   typedef enum logic [1:0] {
      CHECK_PREDICTED,
      CHECK_SILENT,
      CHECK_WORD
   } check_kind_type;

   typedef struct {
      logic [dmcs_pkg::OP_W-1:0]     op;
      logic [dmcs_pkg::CODE_W-1:0]   code;
      logic [dmcs_pkg::COLUMN_W-1:0] column;
      logic [dmcs_pkg::VALUE_W-1:0]  value;
      check_kind_type                chk;
      logic [dmcs_pkg::VALUE_W-1:0]  exp_word;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   dmcs_req_if req_ch ();
   dmcs_rsp_if rsp_ch ();

   dot_matrix_char_serializer #(
      .CHARS_PER_FRAME (CHARS_PER_FRAME),
      .GLYPH_COUNT     (GLYPH_COUNT),
      .GLYPH_COLUMNS   (GLYPH_COLUMNS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Directed words: control-word extremes and the usual start-up words, glyph
   // loads at the code extremes, ignored words, and a frame cut short.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{dmcs_pkg::OP_CTRL, 7'd0,   3'd0, 8'h81, CHECK_WORD,      8'h81},
      '{dmcs_pkg::OP_CTRL, 7'd0,   3'd0, 8'h4d, CHECK_WORD,      8'h4d},
      '{dmcs_pkg::OP_CTRL, 7'd127, 3'd7, 8'hff, CHECK_WORD,      8'hff},
      '{dmcs_pkg::OP_CTRL, 7'd0,   3'd0, 8'h00, CHECK_WORD,      8'h00},
      '{dmcs_pkg::OP_FONT, 7'd0,   3'd0, 8'hff, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd0,   3'd1, 8'hff, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd0,   3'd2, 8'hff, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd0,   3'd3, 8'hff, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd0,   3'd4, 8'hff, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd127, 3'd0, 8'h00, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd127, 3'd1, 8'h55, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd127, 3'd2, 8'h2a, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd127, 3'd3, 8'h80, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd127, 3'd4, 8'h7f, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd0,   3'd5, 8'h00, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_FONT, 7'd0,   3'd7, 8'h00, CHECK_SILENT,    8'h00},
      '{OP_UNUSED,         7'd127, 3'd7, 8'hff, CHECK_SILENT,    8'h00},
      '{dmcs_pkg::OP_CHAR, 7'd0,   3'd0, 8'h00, CHECK_PREDICTED, 8'h00},
      '{dmcs_pkg::OP_CHAR, 7'd127, 3'd7, 8'hff, CHECK_PREDICTED, 8'h00},
      '{dmcs_pkg::OP_CTRL, 7'd0,   3'd0, 8'h01, CHECK_WORD,      8'h01},
      '{dmcs_pkg::OP_CHAR, 7'd127, 3'd0, 8'h00, CHECK_PREDICTED, 8'h00},
      '{dmcs_pkg::OP_CHAR, 7'd0,   3'd0, 8'h00, CHECK_PREDICTED, 8'h00},
      '{dmcs_pkg::OP_CHAR, 7'd0,   3'd0, 8'h00, CHECK_PREDICTED, 8'h00},
      '{dmcs_pkg::OP_CHAR, 7'd127, 3'd0, 8'h00, CHECK_PREDICTED, 8'h00},
      '{dmcs_pkg::OP_CHAR, 7'd0,   3'd0, 8'h00, CHECK_PREDICTED, 8'h00}
   };

   // Predictor state: the glyph store and the position in the open frame.
   logic [dmcs_pkg::DOTS_W-1:0] glyph_mem [GLYPH_COUNT][GLYPH_COLUMNS];
   int                          chars_in_frame = 0;
   serial_bit_type              staged_bits [$];
   serial_bit_type              expected_bits [$];

   // Stimulus bookkeeping: which glyphs are fully loaded and may be shown.
   logic [GLYPH_COLUMNS-1:0]    loaded_cols [GLYPH_COUNT];
   logic                        glyph_ready [GLYPH_COUNT];
   logic [dmcs_pkg::CODE_W-1:0] ready_codes [$];

   // Check kind of the word currently offered, moved along with its payload.
   check_kind_type               drive_check;
   logic [dmcs_pkg::VALUE_W-1:0] drive_word;

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   bit holdoff_request = 0;
   bit holdoff_taken   = 0;
   int holdoff_left    = 0;

   int counted_items  = 0;
   int chars_sent     = 0;
   int ctrl_sent      = 0;
   int font_sent      = 0;
   int ignored_sent   = 0;
   int bits_checked   = 0;
   int frames_latched = 0;
   int mismatch_count = 0;
   int idle_cycles    = 0;

   always #1 clock = ~clock;

   // Works out the serial bits that one accepted word causes.
   task automatic predict_item(input logic [dmcs_pkg::OP_W-1:0] op,
                               input logic [dmcs_pkg::CODE_W-1:0] code,
                               input logic [dmcs_pkg::COLUMN_W-1:0] column,
                               input logic [dmcs_pkg::VALUE_W-1:0] value);
      logic [dmcs_pkg::COLUMN_BITS-1:0] column_bits;
      logic                             opens;
      logic                             closes;
      logic                             tail;
      case (op)
         dmcs_pkg::OP_FONT: begin
            if (code < GLYPH_COUNT && column < GLYPH_COLUMNS) begin
               glyph_mem[code][column] = value[dmcs_pkg::DOTS_W-1:0];
            end
         end
         dmcs_pkg::OP_CTRL: begin
            // A control word closes any partial frame and is a frame of its own.
            chars_in_frame = 0;
            for (int b = dmcs_pkg::COLUMN_BITS - 1; b >= 0; b--) begin
               staged_bits.push_back('{value[b], 1'b1, b == dmcs_pkg::COLUMN_BITS - 1,
                                       b == 0, b == 0});
            end
         end
         dmcs_pkg::OP_CHAR: begin
            opens  = (chars_in_frame == 0);
            closes = (chars_in_frame >= CHARS_PER_FRAME - 1);
            for (int c = GLYPH_COLUMNS - 1; c >= 0; c--) begin
               // Each column leads with a zero bit, then dots 0 through 6.
               column_bits = '0;
               if (code < GLYPH_COUNT) begin
                  column_bits = {glyph_mem[code][c], 1'b0};
               end
               for (int b = 0; b < dmcs_pkg::COLUMN_BITS; b++) begin
                  tail = (c == 0 && b == dmcs_pkg::COLUMN_BITS - 1);
                  staged_bits.push_back('{column_bits[b], 1'b0,
                                          opens && c == GLYPH_COLUMNS - 1 && b == 0,
                                          closes && tail, tail});
               end
            end
            chars_in_frame = closes ? 0 : chars_in_frame + 1;
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input serial_bit_type want,
                                  input serial_bit_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] %s: expected data=%b rs=%b fs=%b fe=%b last=%b,",
                  $time, what, want.data_bit, want.reg_select, want.frame_start,
                  want.frame_end, want.last);
         $display("    got data=%b rs=%b fs=%b fe=%b last=%b",
                  got.data_bit, got.reg_select, got.frame_start, got.frame_end,
                  got.last);
      end
   endtask

   // Offers one word after a random gap and waits until it is accepted.
   task automatic offer(input logic [dmcs_pkg::OP_W-1:0] op,
                        input logic [dmcs_pkg::CODE_W-1:0] code,
                        input logic [dmcs_pkg::COLUMN_W-1:0] column,
                        input logic [dmcs_pkg::VALUE_W-1:0] value,
                        input check_kind_type chk,
                        input logic [dmcs_pkg::VALUE_W-1:0] exp_word);
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.op     <= op;
      req_ch.code   <= code;
      req_ch.column <= column;
      req_ch.value  <= value;
      drive_check   <= chk;
      drive_word    <= exp_word;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);

      // Accepted at this edge; track loaded glyphs and what was covered.
      if (op == OP_UNUSED || (op == dmcs_pkg::OP_FONT && column >= GLYPH_COLUMNS)) begin
         ignored_sent++;
      end else begin
         counted_items++;
         case (op)
            dmcs_pkg::OP_CHAR: chars_sent++;
            dmcs_pkg::OP_CTRL: ctrl_sent++;
            default: begin
               font_sent++;
               loaded_cols[code][column] = 1'b1;
               if (&loaded_cols[code] && !glyph_ready[code]) begin
                  glyph_ready[code] = 1'b1;
                  ready_codes.push_back(code);
               end
            end
         endcase
      end
   endtask

   // Prediction on every accepted word and checking of every accepted bit.
   always @(posedge clock) begin
      serial_bit_type got;
      serial_bit_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            predict_item(req_ch.op, req_ch.code, req_ch.column, req_ch.value);
            if (drive_check == CHECK_PREDICTED) begin
               while (staged_bits.size() != 0) expected_bits.push_back(staged_bits.pop_front());
            end else begin
               staged_bits.delete();
               if (drive_check == CHECK_WORD) begin
                  for (int b = dmcs_pkg::COLUMN_BITS - 1; b >= 0; b--) begin
                     expected_bits.push_back('{drive_word[b], 1'b1,
                                               b == dmcs_pkg::COLUMN_BITS - 1,
                                               b == 0, b == 0});
                  end
               end
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.data_bit, rsp_ch.reg_select, rsp_ch.frame_start,
                    rsp_ch.frame_end, rsp_ch.last};
            if (expected_bits.size() == 0) begin
               report_mismatch("unexpected bit", 'x, got);
            end else begin
               want = expected_bits.pop_front();
               bits_checked++;
               if (want.frame_end && !want.reg_select) frames_latched++;
               if (got !== want) report_mismatch("bit mismatch", want, got);
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off once it is requested.
   always @(posedge clock) begin
      if (holdoff_request && !holdoff_taken) begin
         holdoff_left  = HOLDOFF_CYCLES;
         holdoff_taken = 1;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
      end
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d idle cycles, %0d bits still expected",
                     idle_cycles, expected_bits.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int unsigned                 pick;
      int                          run_len;
      int                          phase;
      logic [dmcs_pkg::CODE_W-1:0] code;

      reset <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.op     <= dmcs_pkg::OP_CHAR;
      req_ch.code   <= '0;
      req_ch.column <= '0;
      req_ch.value  <= '0;
      drive_check   <= CHECK_PREDICTED;
      drive_word    <= '0;
      for (int g = 0; g < GLYPH_COUNT; g++) begin
         loaded_cols[g] = '0;
         glyph_ready[g] = 1'b0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table, with light stalls on both sides.
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      foreach (directed_rows[i]) begin
         offer(directed_rows[i].op, directed_rows[i].code, directed_rows[i].column,
               directed_rows[i].value, directed_rows[i].chk, directed_rows[i].exp_word);
      end

      // Random bursts; the first phase opens with a long receiver hold-off.
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      holdoff_request = 1;
      while (counted_items < ITEM_TARGET) begin
         phase = (counted_items - DIRECTED_ROWS) * 4 / (ITEM_TARGET - DIRECTED_ROWS);
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            // Glyph load, now and then left incomplete.
            code = dmcs_pkg::CODE_W'($urandom_range(0, GLYPH_COUNT - 1));
            for (int c = GLYPH_COLUMNS - 1; c >= 0; c--) begin
               if ($urandom_range(0, 9) != 0) begin
                  offer(dmcs_pkg::OP_FONT, code, dmcs_pkg::COLUMN_W'(c),
                        dmcs_pkg::VALUE_W'($urandom_range(0, 255)), CHECK_PREDICTED, '0);
               end
            end
         end else if (pick < 70) begin
            // Character run that may span or cut short a frame.
            run_len = $urandom_range(1, 12);
            repeat (run_len) begin
               offer(dmcs_pkg::OP_CHAR,
                     ready_codes[$urandom_range(0, ready_codes.size() - 1)],
                     dmcs_pkg::COLUMN_W'($urandom_range(0, 7)),
                     dmcs_pkg::VALUE_W'($urandom_range(0, 255)), CHECK_PREDICTED, '0);
            end
         end else if (pick < 88) begin
            offer(dmcs_pkg::OP_CTRL, dmcs_pkg::CODE_W'($urandom_range(0, 127)),
                  dmcs_pkg::COLUMN_W'($urandom_range(0, 7)),
                  dmcs_pkg::VALUE_W'($urandom_range(0, 255)), CHECK_PREDICTED, '0);
         end else if (pick < 94) begin
            offer(OP_UNUSED, dmcs_pkg::CODE_W'($urandom_range(0, 127)),
                  dmcs_pkg::COLUMN_W'($urandom_range(0, 7)),
                  dmcs_pkg::VALUE_W'($urandom_range(0, 255)), CHECK_PREDICTED, '0);
         end else begin
            offer(dmcs_pkg::OP_FONT, dmcs_pkg::CODE_W'($urandom_range(0, 127)),
                  dmcs_pkg::COLUMN_W'($urandom_range(GLYPH_COLUMNS, 7)),
                  dmcs_pkg::VALUE_W'($urandom_range(0, 255)), CHECK_PREDICTED, '0);
         end
      end
      req_ch.valid <= 1'b0;

      // Drain the remaining bits, then give the back end time to settle.
      recv_stall_pct = 0;
      while (expected_bits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters (%0d frames latched), %0d control words,",
               chars_sent, frames_latched, ctrl_sent);
      $display("%0d glyph column loads and %0d ignored words; checked %0d bits, %0d mismatches",
               font_sent, ignored_sent, bits_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
